// File: hw/rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at each rising clock edge outside reset.
`define TMRAF_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) else $error(msg);

// An implication checked at each rising clock edge outside reset.
`define TMRAF_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/tmraf_pkg.sv
// Package with the shared types, constants and the gain table of the filter.
package tmraf_pkg;

    localparam int UV_W  = 24;
    localparam int SUM_W = 28;
    localparam int FS_W  = 23;
    localparam int DEN_W = 5;

    localparam logic REG_PH  = 1'b0;
    localparam logic REG_ORP = 1'b1;

    typedef struct packed {
        logic take_in;
        logic do_mul;
        logic do_acc;
        logic trim_start;
        logic trim_empty;
        logic ring_wr;
        logic sum_rd;
        logic sum_add;
        logic div2_start;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic in_clear;
        logic last_sample;
        logic no_valid;
        logic div_done;
        logic sum_last;
        logic out_free;
    } sts_t;

    function automatic logic [FS_W-1:0] full_scale_uv(input logic [2:0] code);
        logic [FS_W-1:0] fs;
        unique case (code)
            3'd0:    fs = 23'd6144000;
            3'd1:    fs = 23'd4096000;
            3'd2:    fs = 23'd2048000;
            3'd3:    fs = 23'd1024000;
            3'd4:    fs = 23'd512000;
            3'd5:    fs = 23'd256000;
            default: fs = 23'd4096000;
        endcase
        return fs;
    endfunction

endpackage

// File: hw/rtl/tmraf_stream_if.sv
// Stream interfaces for the sample items and the result items.
interface tmraf_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic               channel;
    logic signed [15:0] sample;
    logic               sample_ok;

    modport source (output valid, command, channel, sample, sample_ok, input ready);
    modport sink   (input valid, command, channel, sample, sample_ok, output ready);
endinterface

interface tmraf_out_if;
    logic               valid;
    logic               ready;
    logic               out_channel;
    logic signed [23:0] filtered_uv;
    logic               filtered_ok;
    logic [4:0]         fill_level;

    modport source (output valid, out_channel, filtered_uv, filtered_ok, fill_level,
                    input ready);
    modport sink   (input valid, out_channel, filtered_uv, filtered_ok, fill_level,
                    output ready);
endinterface

// File: hw/rtl/tmraf_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating.
module tmraf_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [tmraf_pkg::SUM_W-1:0] num,
    input  logic [tmraf_pkg::DEN_W-1:0]       den,
    output logic                              done,
    output logic signed [tmraf_pkg::SUM_W-1:0] quo
);
    localparam int W  = tmraf_pkg::SUM_W;
    localparam int DW = tmraf_pkg::DEN_W;
    localparam int CW = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [W-1:0]  q_reg, q_next;
    logic [DW-1:0] den_reg, den_next;
    logic          neg_reg, neg_next;
    logic [DW:0]   rem_sh;
    logic          q_bit;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        rem_sh    = {rem_reg[DW-1:0], q_reg[W-1]};
        q_bit     = (rem_sh >= {1'b0, den_reg});
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W);
            rem_next  = '0;
            q_next    = num[W-1] ? W'(-num) : W'(num);
            den_next  = den;
            neg_next  = num[W-1];
        end
        else if (busy_reg)
        begin
            rem_next = q_bit ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            q_next   = {q_reg[W-2:0], q_bit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed(q_reg) : $signed(q_reg);
endmodule

// File: hw/rtl/tmraf_ctrl.sv
// Controller state machine that sequences the filter datapath.
module tmraf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  tmraf_pkg::sts_t  sts,
    output tmraf_pkg::cmd_t  cmd
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_ACC  = 4'd2;
    localparam logic [3:0] S_TRIM = 4'd3;
    localparam logic [3:0] S_DIV1 = 4'd4;
    localparam logic [3:0] S_WR   = 4'd5;
    localparam logic [3:0] S_RD   = 4'd6;
    localparam logic [3:0] S_ADD  = 4'd7;
    localparam logic [3:0] S_DIV2S = 4'd8;
    localparam logic [3:0] S_DIV2 = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    if (!sts.in_clear)
                        state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.do_mul = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.do_acc = 1'b1;
                state_next = sts.last_sample ? S_TRIM : S_IDLE;
            end
            S_TRIM:
            begin
                if (sts.no_valid)
                begin
                    cmd.trim_empty = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.trim_start = 1'b1;
                    state_next     = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (sts.div_done)
                    state_next = S_WR;
            end
            S_WR:
            begin
                cmd.ring_wr = 1'b1;
                state_next  = S_RD;
            end
            S_RD:
            begin
                cmd.sum_rd = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.sum_add = 1'b1;
                state_next  = sts.sum_last ? S_DIV2S : S_RD;
            end
            S_DIV2S:
            begin
                cmd.div2_start = 1'b1;
                state_next     = S_DIV2;
            end
            S_DIV2:
            begin
                if (sts.div_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

// File: hw/rtl/tmraf_datapath.sv
// Datapath: scaling, batch statistics, ring memory, sums and result register.
module tmraf_datapath #(
    parameter int BATCH_SAMPLES = 10,
    parameter int AVG_WINDOW    = 5
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  tmraf_pkg::cmd_t           cmd,
    output tmraf_pkg::sts_t           sts,
    input  logic                      in_command,
    input  logic                      in_channel,
    input  logic signed [15:0]        in_sample,
    input  logic                      in_sample_ok,
    input  logic [2:0]                ph_gain,
    input  logic [2:0]                orp_gain,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      out_channel,
    output logic signed [23:0]        filtered_uv,
    output logic                      filtered_ok,
    output logic [4:0]                fill_level
);
    localparam int UW = tmraf_pkg::UV_W;
    localparam int SW = tmraf_pkg::SUM_W;
    localparam int DW = tmraf_pkg::DEN_W;
    localparam int FW = $clog2(AVG_WINDOW + 1);
    localparam int DEPTH = 2 * AVG_WINDOW;
    localparam int AW = $clog2(DEPTH);

    logic                 ch_reg;
    logic signed [15:0]   smp_reg;
    logic                 sok_reg;
    logic signed [39:0]   prod_reg;
    logic [3:0]           cnt_reg;
    logic [3:0]           nval_reg;
    logic signed [SW-1:0] sum_reg;
    logic signed [UW-1:0] min_reg;
    logic signed [UW-1:0] max_reg;
    logic [FW-1:0]        fill_reg [2];
    logic [FW-1:0]        pos_reg [2];
    logic [UW-1:0]        ring_mem [DEPTH];
    logic signed [UW-1:0] rd_reg;
    logic [FW-1:0]        idx_reg;
    logic signed [SW-1:0] acc_reg;
    logic                 res_ok_reg;
    logic                 oval_reg;
    logic                 och_reg;
    logic signed [UW-1:0] ouv_reg;
    logic                 ook_reg;
    logic [4:0]           ofill_reg;

    logic [tmraf_pkg::FS_W-1:0] fs;
    logic signed [39:0]   prod_adj;
    logic signed [UW-1:0] v;
    logic signed [SW-1:0] div_num;
    logic [DW-1:0]        div_den;
    logic                 div_start;
    logic                 div_done;
    logic signed [SW-1:0] div_quo;
    logic [AW-1:0]        base;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic [FW-1:0]        cur_fill;
    logic [FW-1:0]        cur_pos;

    assign fs       = tmraf_pkg::full_scale_uv(ch_reg ? orp_gain : ph_gain);
    assign prod_adj = prod_reg + (prod_reg[39] ? 40'sd32767 : 40'sd0);
    assign v        = prod_adj[38:15];
    assign cur_fill = fill_reg[ch_reg];
    assign cur_pos  = pos_reg[ch_reg];
    assign base     = ch_reg ? AW'(AVG_WINDOW) : '0;
    assign wr_addr  = base + AW'(cur_pos);
    assign rd_addr  = base + AW'(idx_reg);

    always_comb
    begin
        if (cmd.div2_start)
        begin
            div_num = acc_reg;
            div_den = DW'(cur_fill);
        end
        else if (nval_reg <= 4'd2)
        begin
            div_num = sum_reg;
            div_den = {1'b0, nval_reg};
        end
        else
        begin
            div_num = sum_reg - SW'(min_reg) - SW'(max_reg);
            div_den = {1'b0, nval_reg - 4'd2};
        end
    end

    assign div_start = cmd.trim_start | cmd.div2_start;

    tmraf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Input capture, product, ring memory read and write, and output registers.
    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            ch_reg  <= in_channel;
            smp_reg <= in_sample;
            sok_reg <= in_sample_ok;
        end
        if (cmd.do_mul)
            prod_reg <= 40'(smp_reg * $signed({1'b0, fs}));
        if (cmd.sum_rd)
            rd_reg <= ring_mem[rd_addr];
        if (cmd.ring_wr)
            ring_mem[wr_addr] <= div_quo[UW-1:0];
        if (cmd.load_out)
        begin
            och_reg   <= ch_reg;
            ouv_reg   <= res_ok_reg ? div_quo[UW-1:0] : '0;
            ook_reg   <= res_ok_reg;
            ofill_reg <= 5'(cur_fill);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            nval_reg   <= '0;
            sum_reg    <= '0;
            min_reg    <= '0;
            max_reg    <= '0;
            fill_reg   <= '{default: '0};
            pos_reg    <= '{default: '0};
            idx_reg    <= '0;
            acc_reg    <= '0;
            res_ok_reg <= 1'b0;
            oval_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.take_in && in_command)
            begin
                fill_reg[in_channel] <= '0;
                pos_reg[in_channel]  <= '0;
            end
            if (cmd.do_acc)
            begin
                cnt_reg <= (cnt_reg == 4'(BATCH_SAMPLES - 1)) ? 4'd0 : cnt_reg + 4'd1;
                if (sok_reg)
                begin
                    if (nval_reg == 4'd0)
                    begin
                        min_reg <= v;
                        max_reg <= v;
                    end
                    else
                    begin
                        if (v < min_reg)
                            min_reg <= v;
                        if (v > max_reg)
                            max_reg <= v;
                    end
                    sum_reg  <= sum_reg + SW'(v);
                    nval_reg <= nval_reg + 4'd1;
                end
            end
            if (cmd.trim_empty || cmd.trim_start)
                res_ok_reg <= cmd.trim_start;
            if (cmd.trim_empty || cmd.ring_wr)
            begin
                nval_reg <= '0;
                sum_reg  <= '0;
                min_reg  <= '0;
                max_reg  <= '0;
            end
            if (cmd.ring_wr)
            begin
                pos_reg[ch_reg] <= (cur_pos == FW'(AVG_WINDOW - 1)) ? '0 : cur_pos + 1'b1;
                if (cur_fill < FW'(AVG_WINDOW))
                    fill_reg[ch_reg] <= cur_fill + 1'b1;
                idx_reg <= '0;
                acc_reg <= '0;
            end
            if (cmd.sum_add)
            begin
                acc_reg <= acc_reg + SW'(rd_reg);
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.load_out)
                oval_reg <= 1'b1;
            else if (out_ready)
                oval_reg <= 1'b0;
        end
    end

    assign sts.in_clear    = in_command;
    assign sts.last_sample = (cnt_reg == 4'(BATCH_SAMPLES - 1));
    assign sts.no_valid    = (nval_reg == 4'd0);
    assign sts.div_done    = div_done;
    assign sts.sum_last    = ((idx_reg + 1'b1) == cur_fill);
    assign sts.out_free    = !oval_reg || out_ready;

    assign out_valid   = oval_reg;
    assign out_channel = och_reg;
    assign filtered_uv = ouv_reg;
    assign filtered_ok = ook_reg;
    assign fill_level  = ofill_reg;
endmodule

// File: hw/rtl/trimmed_mean_rolling_average_filter.sv
// Top level of the two-channel trimmed-mean and rolling-average filter.
//
//  Channel   Direction  Contents
//  in_ch     sink       command, channel, sample, sample_ok
//  out_ch    source     out_channel, filtered_uv, filtered_ok, fill_level
//  APB       slave      gain code registers at byte addresses 0 and 4
//
// A sample item that does not end a batch passes capture, multiply by the
// full scale and accumulate; a clear item only empties its channel's ring.
// The item that ends a batch also uses the shared bit-serial divider twice,
// unless no sample of the batch was valid, and sweeps the filled ring slots.
// Reset is asynchronous and active low; the ring memory is not cleared, as
// only filled slots are ever read. A result waits in the output register,
// and the block takes the next item while it waits; a stalled output blocks
// only the next batch end.
module trimmed_mean_rolling_average_filter #(
    parameter int BATCH_SAMPLES = 10,
    parameter int AVG_WINDOW    = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    tmraf_in_if.sink    in_ch,
    tmraf_out_if.source out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [2:0]      ph_gain_reg;
    logic [2:0]      orp_gain_reg;
    tmraf_pkg::cmd_t cmd;
    tmraf_pkg::sts_t sts;

    // Register file: the index is the word address bit, other bits are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_gain_reg  <= 3'd1;
            orp_gain_reg <= 3'd1;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == tmraf_pkg::REG_PH)
                ph_gain_reg <= pwdata[2:0];
            else
                orp_gain_reg <= pwdata[2:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == tmraf_pkg::REG_PH) ? {29'd0, ph_gain_reg}
                                                    : {29'd0, orp_gain_reg};

    // The controller sequences every item; the datapath holds the sample, batch and ring values.
    tmraf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tmraf_datapath #(
        .BATCH_SAMPLES (BATCH_SAMPLES),
        .AVG_WINDOW    (AVG_WINDOW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_command   (in_ch.command),
        .in_channel   (in_ch.channel),
        .in_sample    (in_ch.sample),
        .in_sample_ok (in_ch.sample_ok),
        .ph_gain      (ph_gain_reg),
        .orp_gain     (orp_gain_reg),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .out_channel  (out_ch.out_channel),
        .filtered_uv  (out_ch.filtered_uv),
        .filtered_ok  (out_ch.filtered_ok),
        .fill_level   (out_ch.fill_level)
    );
endmodule

// File: hw/rtl/tmraf_checker.sv
// Port checker for the filter and its bind to the top level.
`include "assert_macros.svh"

module tmraf_checker #(
    parameter int AVG_WINDOW = 5
) (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [23:0] filtered_uv,
    input logic               filtered_ok,
    input logic [4:0]         fill_level
);
    `TMRAF_ASSERT_IMPLY(a_out_hold, clk, rst_n, out_valid && !out_ready, ##1 out_valid, "result item dropped while stalled")
    `TMRAF_ASSERT_IMPLY(a_bad_zero, clk, rst_n, out_valid && !filtered_ok, filtered_uv == 24'sd0, "invalid batch with nonzero value")
    `TMRAF_ASSERT_IMPLY(a_fill_max, clk, rst_n, out_valid, fill_level <= 5'(AVG_WINDOW), "fill level beyond window")
    `TMRAF_ASSERT(a_ok_fill, clk, rst_n, !(out_valid && filtered_ok && fill_level == 5'd0), "valid result with empty ring")
endmodule

bind trimmed_mean_rolling_average_filter tmraf_checker #(
    .AVG_WINDOW (AVG_WINDOW)
) u_tmraf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .filtered_uv (out_ch.filtered_uv),
    .filtered_ok (out_ch.filtered_ok),
    .fill_level  (out_ch.fill_level)
);
